@@ design/rbt_pkg.sv @@
// Package for the reversible byte transform: widths, register indexes,
// and the byte helper functions shared by the datapath. No dependencies.
`timescale 1ns / 1ps
package rbt_pkg;
    localparam int BYTE_W = 8;
    localparam int OP_W   = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OP_SELECT = 1'b0,
        REG_DIRECTION = 1'b1
    } cfg_reg_t;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef logic [255:0][BYTE_W-1:0] byte_tab_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            inverse;
    } rbt_ctrl_t;

    function automatic byte_t rotl(input byte_t x, input logic [2:0] k);
        logic [15:0] d;
        d = {x, x} << k;
        return d[15:8];
    endfunction

    function automatic byte_t bit_rev(input byte_t b);
        byte_t r;
        for (int i = 0; i < BYTE_W; i++) r[i] = b[BYTE_W-1-i];
        return r;
    endfunction

    function automatic byte_t gray_inv(input byte_t g);
        byte_t r;
        r = g ^ (g >> 4);
        r = r ^ (r >> 2);
        r = r ^ (r >> 1);
        return r;
    endfunction

    function automatic byte_t xtime(input byte_t a);
        return a[7] ? ((a << 1) ^ 8'h1B) : (a << 1);
    endfunction

    function automatic byte_t gf_mul(input byte_t a, input byte_t b);
        byte_t r;
        byte_t t;
        r = '0;
        t = a;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (b[i]) r = r ^ t;
            t = xtime(t);
        end
        return r;
    endfunction

    // walk the powers of the generator 3; the inverse of 3^i is 3^(255-i)
    function automatic byte_tab_t gf_inv_table();
        byte_tab_t e;
        byte_tab_t t;
        byte_t     x;
        e = '0;
        t = '0;
        x = 8'h01;
        for (int i = 0; i < 255; i++)
        begin
            e[i] = x;
            x    = xtime(x) ^ x;
        end
        for (int i = 0; i < 255; i++)
            t[e[i]] = e[(i == 0) ? 0 : 255 - i];
        t[0] = 8'h01;
        return t;
    endfunction

    // table of field inverses, built at elaboration
    localparam byte_tab_t GF_INV_TAB = gf_inv_table();

    function automatic byte_t gf_inv(input byte_t a);
        return GF_INV_TAB[a];
    endfunction

    function automatic byte_t mul_inv_calc(input byte_t n);
        byte_t x;
        x = n;
        for (int k = 0; k < 3; k++) x = byte_t'(x * byte_t'(8'd2 - byte_t'(n * x)));
        return x;
    endfunction

    function automatic byte_tab_t mul_inv_table();
        byte_tab_t t;
        for (int i = 0; i < 256; i++) t[i] = mul_inv_calc(byte_t'(i));
        return t;
    endfunction

    localparam byte_tab_t MUL_INV_TAB = mul_inv_table();

    // inverse of an odd byte modulo 256
    function automatic byte_t mul_inv(input byte_t n);
        return MUL_INV_TAB[n];
    endfunction

    function automatic byte_t nswap(input byte_t x);
        return {x[3:0], x[7:4]};
    endfunction
endpackage

@@ design/rbt_stream_if.sv @@
// Valid/ready stream interface carrying one byte and a last flag.
// Depends on rbt_pkg.
`timescale 1ns / 1ps
interface rbt_stream_if;
    logic           valid;
    logic           ready;
    rbt_pkg::byte_t data;
    logic           last;
    modport source (output valid, output data, output last, input ready);
    modport sink   (input valid, input data, input last, output ready);
endinterface

@@ design/rbt_datapath.sv @@
// Combinational transform of one byte, forward or inverse.
// Depends on rbt_pkg.
`timescale 1ns / 1ps
module rbt_datapath (
    input  rbt_pkg::rbt_ctrl_t ctrl,
    input  rbt_pkg::byte_t     c,
    input  rbt_pkg::byte_t     p,
    input  rbt_pkg::byte_t     q,
    input  rbt_pkg::byte_t     ix,
    output rbt_pkg::byte_t     r
);
    import rbt_pkg::*;

    byte_t pl, ph, ql, qh, pn, gp, gq, ipx, mulop, mulinv;
    byte_t ginv_p, ginv_q;

    assign pl  = {4'h0, p[3:0]};
    assign ph  = {4'h0, p[7:4]};
    assign ql  = {4'h0, q[3:0]};
    assign qh  = {4'h0, q[7:4]};
    assign pn  = nswap(p);
    assign gp  = (p == '0) ? 8'h01 : p;
    assign gq  = (q == '0) ? 8'h01 : q;
    assign ipx = ix ^ p;

    // shared multiplier operand
    always_comb
    begin
        unique case (ctrl.op)
            6'd2:    mulop = p | 8'h01;
            6'd25:   mulop = ix | 8'h01;
            6'd30:   mulop = ph | 8'h01;
            6'd31:   mulop = pl | 8'h01;
            6'd44:   mulop = q | 8'h01;
            6'd56:   mulop = pn | 8'h01;
            default: mulop = ipx | 8'h01;
        endcase
    end

    assign mulinv = mul_inv(mulop);
    assign ginv_p = gf_inv(gp);
    assign ginv_q = gf_inv(gq);

    always_comb
    begin
        r = c;
        if (!ctrl.inverse)
        begin
            unique case (ctrl.op)
                6'd0:  r = c + p;
                6'd1:  r = c ^ p;
                6'd2, 6'd25, 6'd30, 6'd31, 6'd44, 6'd56, 6'd60:
                       r = byte_t'(c * mulop);
                6'd3:  r = c + pl;
                6'd4:  r = nswap(c) ^ p;
                6'd5:  r = gf_mul(c, gp);
                6'd6:  r = rotl(c, 3'd1);
                6'd7:  r = c + ph;
                6'd8:  r = c ^ (c >> 1);
                6'd9:  r = c ^ {p[3:0], p[3:0]};
                6'd10: r = c - pl;
                6'd11: r = c - ph;
                6'd12: r = p - c;
                6'd13: r = c ^ pl;
                6'd14: r = c ^ ph;
                6'd15: r = rotl(c, 3'd7);
                6'd16: r = c - p;
                6'd17: r = c + ix;
                6'd18: r = c - ix;
                6'd19: r = c ^ ix;
                6'd20, 6'd37: r = rotl(c, 3'd2);
                6'd21, 6'd36: r = rotl(c, 3'd6);
                6'd22: r = nswap(c);
                6'd23: r = bit_rev(c);
                6'd24: r = ~c;
                6'd26: r = c + q;
                6'd27: r = c - q;
                6'd28: r = c ^ q;
                6'd29: r = (c << 1) ^ {BYTE_W{c[7]}};
                6'd32, 6'd35: r = rotl(c, 3'd3);
                6'd33, 6'd34: r = rotl(c, 3'd5);
                6'd38: r = c - (p << 1) + q;
                6'd39: r = c + p + q;
                6'd40: r = c - p - q;
                6'd41: r = c ^ (p + q);
                6'd42: r = c + (p ^ q);
                6'd43: r = c - (p ^ q);
                6'd45: r = c + qh;
                6'd46: r = c + ql;
                6'd47: r = c - qh;
                6'd48: r = c - ql;
                6'd49: r = c ^ qh;
                6'd50: r = c ^ ql;
                6'd51: r = gf_mul(c, 8'h02);
                6'd52: r = gf_mul(c, 8'h03);
                6'd53: r = c + pn;
                6'd54: r = c - pn;
                6'd55: r = c ^ pn;
                6'd57: r = c + ipx;
                6'd58: r = c - ipx;
                6'd59: r = c ^ (ix + p);
                6'd61: r = gray_inv(c);
                6'd62: r = gf_mul(c, 8'h05);
                default: r = gf_mul(c, gq);
            endcase
        end
        else
        begin
            unique case (ctrl.op)
                6'd0:  r = c - p;
                6'd1:  r = c ^ p;
                6'd2, 6'd25, 6'd30, 6'd31, 6'd44, 6'd56, 6'd60:
                       r = byte_t'(c * mulinv);
                6'd3:  r = c - pl;
                6'd4:  r = nswap(c ^ p);
                6'd5:  r = gf_mul(c, ginv_p);
                6'd6:  r = rotl(c, 3'd7);
                6'd7:  r = c - ph;
                6'd8:  r = gray_inv(c);
                6'd9:  r = c ^ {p[3:0], p[3:0]};
                6'd10: r = c + pl;
                6'd11: r = c + ph;
                6'd12: r = p - c;
                6'd13: r = c ^ pl;
                6'd14: r = c ^ ph;
                6'd15: r = rotl(c, 3'd1);
                6'd16: r = c + p;
                6'd17: r = c - ix;
                6'd18: r = c + ix;
                6'd19: r = c ^ ix;
                6'd20, 6'd37: r = rotl(c, 3'd6);
                6'd21, 6'd36: r = rotl(c, 3'd2);
                6'd22: r = nswap(c);
                6'd23: r = bit_rev(c);
                6'd24: r = ~c;
                6'd26: r = c - q;
                6'd27: r = c + q;
                6'd28: r = c ^ q;
                6'd29: r = (c >> 1) ^ {BYTE_W{c[0]}};
                6'd32, 6'd35: r = rotl(c, 3'd5);
                6'd33, 6'd34: r = rotl(c, 3'd3);
                6'd38: r = c + (p << 1) - q;
                6'd39: r = c - p - q;
                6'd40: r = c + p + q;
                6'd41: r = c ^ (p + q);
                6'd42: r = c - (p ^ q);
                6'd43: r = c + (p ^ q);
                6'd45: r = c - qh;
                6'd46: r = c - ql;
                6'd47: r = c + qh;
                6'd48: r = c + ql;
                6'd49: r = c ^ qh;
                6'd50: r = c ^ ql;
                6'd51: r = gf_mul(c, gf_inv(8'h02));
                6'd52: r = gf_mul(c, gf_inv(8'h03));
                6'd53: r = c - pn;
                6'd54: r = c + pn;
                6'd55: r = c ^ pn;
                6'd57: r = c - ipx;
                6'd58: r = c + ipx;
                6'd59: r = c ^ (ix + p);
                6'd61: r = c ^ (c >> 1);
                6'd62: r = gf_mul(c, gf_inv(8'h05));
                default: r = gf_mul(c, ginv_q);
            endcase
        end
    end
endmodule

@@ design/reversible_byte_transform_top.sv @@
// Top level of the reversible byte transform: config registers, history,
// output register. Depends on rbt_pkg, rbt_stream_if and rbt_datapath.
`timescale 1ns / 1ps
// Usage:
//   s_in  : sink channel, one byte word plus last flag per handshake.
//   m_out : source channel, the transformed or restored word and its last.
//   cfg_we/cfg_idx/cfg_data: write op_select (index 0) or direction (1)
//   while the stream is idle; other indexes are dropped.
// Output: the transformed word is written into the output register on acceptance.
// Throughput: one word per cycle while the receiver is ready; the byte
// history, position count and transform logic all update on acceptance,
// so the next word may enter immediately after the previous one.
// Reset: configuration, history and position clear to zero; the output
// register is empty. History and position also clear after a word
// flagged last.
// Stall: while the output word is held and the receiver is not ready,
// input ready drops; the output word holds until taken.
module reversible_byte_transform_top (
    input  logic                               clk,
    input  logic                               rst_n,
    rbt_stream_if.sink                         s_in,
    rbt_stream_if.source                       m_out,
    input  logic                               cfg_we,
    input  logic [rbt_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [rbt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rbt_pkg::*;

    rbt_ctrl_t ctrl_reg;
    byte_t     p_reg, q_reg, ix_reg, p_next, q_next, ix_next;
    byte_t     r;
    byte_t     data_reg;
    logic      last_reg, valid_reg;
    logic      accept;

    assign s_in.ready = !valid_reg || m_out.ready;
    assign accept     = s_in.valid && s_in.ready;

    rbt_datapath u_dp (
        .ctrl (ctrl_reg),
        .c    (s_in.data),
        .p    (p_reg),
        .q    (q_reg),
        .ix   (ix_reg),
        .r    (r)
    );

    always_comb
    begin
        p_next  = p_reg;
        q_next  = q_reg;
        ix_next = ix_reg;
        if (accept)
        begin
            if (s_in.last)
            begin
                p_next  = '0;
                q_next  = '0;
                ix_next = '0;
            end
            else
            begin
                q_next  = p_reg;
                p_next  = ctrl_reg.inverse ? r : s_in.data;
                ix_next = ix_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg  <= '0;
            p_reg     <= '0;
            q_reg     <= '0;
            ix_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            p_reg  <= p_next;
            q_reg  <= q_next;
            ix_reg <= ix_next;
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_idx))
                    REG_OP_SELECT: ctrl_reg.op      <= cfg_data[OP_W-1:0];
                    REG_DIRECTION: ctrl_reg.inverse <= cfg_data[0];
                    default: ;
                endcase
            end
            if (accept)                valid_reg <= 1'b1;
            else if (m_out.ready)      valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= r;
            last_reg <= s_in.last;
        end
    end

    assign m_out.valid = valid_reg;
    assign m_out.data  = data_reg;
    assign m_out.last  = last_reg;

`ifndef ASSERT_OFF
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_out.valid && !m_out.ready) |-> !s_in.ready)
        else $error("input taken while output word stalled");
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_in.last) |=> (ix_reg == '0 && p_reg == '0 && q_reg == '0))
        else $error("history not cleared after last");
    a_pos_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_in.last) |=> ix_reg == byte_t'($past(ix_reg) + 8'd1))
        else $error("position did not advance");
    a_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_out.valid)
        else $error("accepted word not presented");
`endif
endmodule

@@ verif/testbench.sv @@
// Self-checking bench for reversible_byte_transform_top: sweeps every transform
// in both directions, predicts each output word in-bench and compares them in order.
// Depends on rbt_pkg, rbt_stream_if and the top level in design/.
`timescale 1ns / 1ps
module testbench;
    import rbt_pkg::*;

    typedef struct {
        byte_t data;
        logic  last;
    } word_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    rbt_stream_if s_in();
    rbt_stream_if m_out();

    reversible_byte_transform_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_in     (s_in.sink),
        .m_out    (m_out.source),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    word_t pending_words[$];
    word_t expected_words[$];
    int    send_idle_pct;
    int    recv_stall_pct;
    int    mismatches;
    int    failures;
    int    words_added;
    int    words_seen;
    logic  want_hold;
    logic  hold_done;
    int    hold_left;

    logic [OP_W-1:0] op_now;
    logic            inverse_now;
    byte_t           hist_p;
    byte_t           hist_q;
    byte_t           pos_now;

    function automatic byte_t rl(input byte_t x, input int k);
        return byte_t'((x << k) | (x >> (8 - k)));
    endfunction

    function automatic byte_t sw(input byte_t x);
        return {x[3:0], x[7:4]};
    endfunction

    function automatic byte_t gfm(input byte_t a, input byte_t b);
        byte_t r;
        r = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i]) r = r ^ a;
            a = a[7] ? byte_t'((a << 1) ^ 8'h1B) : byte_t'(a << 1);
        end
        return r;
    endfunction

    function automatic byte_t gfinv(input byte_t a);
        byte_t r;
        r = 8'h01;
        for (int v = 1; v < 256; v++)
            if (gfm(a, byte_t'(v)) == 8'h01) r = byte_t'(v);
        return r;
    endfunction

    function automatic byte_t minv(input byte_t n);
        byte_t r;
        r = 8'h01;
        for (int v = 1; v < 256; v += 2)
            if (byte_t'(n * byte_t'(v)) == 8'h01) r = byte_t'(v);
        return r;
    endfunction

    function automatic byte_t gray_undo(input byte_t g);
        byte_t r;
        r = g ^ (g >> 4);
        r = r ^ (r >> 2);
        r = r ^ (r >> 1);
        return r;
    endfunction

    function automatic byte_t mirror(input byte_t b);
        byte_t r;
        for (int i = 0; i < 8; i++) r[i] = b[7-i];
        return r;
    endfunction

    function automatic byte_t transform_byte(input logic [OP_W-1:0] op, input logic back,
                                             input byte_t c, input byte_t p,
                                             input byte_t q, input byte_t ix);
        byte_t r;
        byte_t pl;
        byte_t ph;
        byte_t ql;
        byte_t qh;
        pl = p & 8'h0F;
        ph = p >> 4;
        ql = q & 8'h0F;
        qh = q >> 4;
        if (!back)
        begin
            case (op)
                0: r = c + p;
                1: r = c ^ p;
                2: r = c * (p | 8'h01);
                3: r = c + pl;
                4: r = sw(c) ^ p;
                5: r = gfm(c, (p != 0) ? p : 8'h01);
                6: r = rl(c, 1);
                7: r = c + ph;
                8: r = c ^ (c >> 1);
                9: r = c ^ {pl[3:0], pl[3:0]};
                10: r = c - pl;
                11: r = c - ph;
                12: r = p - c;
                13: r = c ^ pl;
                14: r = c ^ ph;
                15: r = rl(c, 7);
                16: r = c - p;
                17: r = c + ix;
                18: r = c - ix;
                19: r = c ^ ix;
                20: r = rl(c, 2);
                21: r = rl(c, 6);
                22: r = sw(c);
                23: r = mirror(c);
                24: r = ~c;
                25: r = c * (ix | 8'h01);
                26: r = c + q;
                27: r = c - q;
                28: r = c ^ q;
                29: r = byte_t'(c << 1) ^ (c[7] ? 8'hFF : 8'h00);
                30: r = c * (ph | 8'h01);
                31: r = c * (pl | 8'h01);
                32, 35: r = rl(c, 3);
                33, 34: r = rl(c, 5);
                36: r = rl(c, 6);
                37: r = rl(c, 2);
                38: r = c - byte_t'(p << 1) + q;
                39: r = c + p + q;
                40: r = c - p - q;
                41: r = c ^ byte_t'(p + q);
                42: r = c + (p ^ q);
                43: r = c - (p ^ q);
                44: r = c * (q | 8'h01);
                45: r = c + qh;
                46: r = c + ql;
                47: r = c - qh;
                48: r = c - ql;
                49: r = c ^ qh;
                50: r = c ^ ql;
                51: r = gfm(c, 8'h02);
                52: r = gfm(c, 8'h03);
                53: r = c + sw(p);
                54: r = c - sw(p);
                55: r = c ^ sw(p);
                56: r = c * (sw(p) | 8'h01);
                57: r = c + (ix ^ p);
                58: r = c - (ix ^ p);
                59: r = c ^ byte_t'(ix + p);
                60: r = c * ((ix ^ p) | 8'h01);
                61: r = gray_undo(c);
                62: r = gfm(c, 8'h05);
                default: r = gfm(c, (q != 0) ? q : 8'h01);
            endcase
        end
        else
        begin
            case (op)
                0: r = c - p;
                1: r = c ^ p;
                2: r = c * minv(p | 8'h01);
                3: r = c - pl;
                4: r = sw(c ^ p);
                5: r = gfm(c, gfinv((p != 0) ? p : 8'h01));
                6: r = rl(c, 7);
                7: r = c - ph;
                8: r = gray_undo(c);
                9: r = c ^ {pl[3:0], pl[3:0]};
                10: r = c + pl;
                11: r = c + ph;
                12: r = p - c;
                13: r = c ^ pl;
                14: r = c ^ ph;
                15: r = rl(c, 1);
                16: r = c + p;
                17: r = c - ix;
                18: r = c + ix;
                19: r = c ^ ix;
                20: r = rl(c, 6);
                21: r = rl(c, 2);
                22: r = sw(c);
                23: r = mirror(c);
                24: r = ~c;
                25: r = c * minv(ix | 8'h01);
                26: r = c - q;
                27: r = c + q;
                28: r = c ^ q;
                29: r = (c >> 1) ^ (c[0] ? 8'hFF : 8'h00);
                30: r = c * minv(ph | 8'h01);
                31: r = c * minv(pl | 8'h01);
                32, 35: r = rl(c, 5);
                33, 34: r = rl(c, 3);
                36: r = rl(c, 2);
                37: r = rl(c, 6);
                38: r = c + byte_t'(p << 1) - q;
                39: r = c - p - q;
                40: r = c + p + q;
                41: r = c ^ byte_t'(p + q);
                42: r = c - (p ^ q);
                43: r = c + (p ^ q);
                44: r = c * minv(q | 8'h01);
                45: r = c - qh;
                46: r = c - ql;
                47: r = c + qh;
                48: r = c + ql;
                49: r = c ^ qh;
                50: r = c ^ ql;
                51: r = gfm(c, gfinv(8'h02));
                52: r = gfm(c, gfinv(8'h03));
                53: r = c - sw(p);
                54: r = c + sw(p);
                55: r = c ^ sw(p);
                56: r = c * minv(sw(p) | 8'h01);
                57: r = c - (ix ^ p);
                58: r = c + (ix ^ p);
                59: r = c ^ byte_t'(ix + p);
                60: r = c * minv((ix ^ p) | 8'h01);
                61: r = c ^ (c >> 1);
                62: r = gfm(c, gfinv(8'h05));
                default: r = gfm(c, gfinv((q != 0) ? q : 8'h01));
            endcase
        end
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_in.valid <= 1'b0;
            s_in.data  <= '0;
            s_in.last  <= 1'b0;
        end
        else if (!s_in.valid || s_in.ready)
        begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_in.valid <= 1'b1;
                s_in.data  <= pending_words[0].data;
                s_in.last  <= pending_words[0].last;
                void'(pending_words.pop_front());
            end
            else
            begin
                s_in.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (want_hold && !hold_done)
        begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_out.ready <= 1'b0;
        else
            m_out.ready <= (hold_left == 0) && !(want_hold && !hold_done)
                           && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        word_t got;
        word_t want;
        if (rst_n && m_out.valid && m_out.ready)
        begin
            words_seen++;
            got.data = m_out.data;
            got.last = m_out.last;
            if (expected_words.size() == 0)
            begin
                failures++;
                if (mismatches < 10)
                    $display("unexpected word data=%02h last=%0b", got.data, got.last);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (got.data !== want.data || got.last !== want.last)
                begin
                    failures++;
                    if (mismatches < 10)
                        $display("mismatch op=%0d inv=%0b: expected %02h/%0b, got %02h/%0b",
                                 op_now, inverse_now, want.data, want.last,
                                 got.data, got.last);
                    mismatches++;
                end
            end
        end
        if (rst_n && s_in.valid && s_in.ready)
        begin
            byte_t orig;
            want.data = transform_byte(op_now, inverse_now, s_in.data, hist_p, hist_q,
                                       pos_now);
            want.last = s_in.last;
            expected_words.push_back(want);
            orig = inverse_now ? want.data : s_in.data;
            if (s_in.last)
            begin
                hist_p  = '0;
                hist_q  = '0;
                pos_now = '0;
            end
            else
            begin
                hist_q  = hist_p;
                hist_p  = orig;
                pos_now = pos_now + 8'd1;
            end
        end
    end

    task automatic set_mode(input logic [OP_W-1:0] op, input logic back);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_OP_SELECT;
        cfg_data <= op;
        op_now = op;
        @(posedge clk);
        cfg_idx  <= REG_DIRECTION;
        cfg_data <= {(CFG_DATA_W-1)'($urandom_range(31)), back};
        inverse_now = back;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_word(input byte_t d, input logic l);
        word_t w;
        w.data = d;
        w.last = l;
        pending_words.push_back(w);
        words_added++;
    endtask

    task automatic drain;
        wait (words_seen == words_added);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = REG_OP_SELECT;
        cfg_data = '0;
        want_hold = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatches = 0;
        failures = 0;
        words_added = 0;
        words_seen = 0;
        op_now = '0;
        inverse_now = 1'b0;
        hist_p = '0;
        hist_q = '0;
        pos_now = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        add_word(8'h00, 1'b0);
        add_word(8'hFF, 1'b0);
        add_word(8'h80, 1'b0);
        add_word(8'h01, 1'b1);
        add_word(8'hFF, 1'b1);
        add_word(8'h7F, 1'b0);
        add_word(8'hAA, 1'b0);
        add_word(8'h55, 1'b1);
        drain();
        set_mode(6'd5, 1'b1);
        add_word(8'h00, 1'b0);
        add_word(8'hFF, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'h3C, 1'b1);
        drain();
        set_mode(6'd63, 1'b1);
        add_word(8'hFF, 1'b0);
        add_word(8'h00, 1'b0);
        add_word(8'hFF, 1'b0);
        add_word(8'h12, 1'b1);
        drain();

        for (int ph = 0; ph < 128; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            set_mode(ph[6:1], ph[0]);
            if (ph == 8)
                want_hold <= 1'b1;
            n = ((ph[6:1] == 17 || ph[6:1] == 57) && !ph[0]) ? 300 : $urandom_range(2, 8);
            for (int k = 0; k < n; k++)
                add_word(byte_t'($urandom_range(255)),
                         (n < 100) && ($urandom_range(7) == 0));
            add_word(byte_t'($urandom_range(255)), 1'($urandom_range(1)));
            drain();
        end

        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
